[rtl/core/bmp24w_pkg.sv]
// bmp24w_pkg: shared constants and types of the 24-bit bmp stream writer
package bmp24w_pkg;

    localparam int DIM_W      = 13;
    localparam int PREC_W     = 5;
    localparam int SAMPLE_W   = 16;
    localparam int ROWB_W     = 15;
    localparam int ISIZE_W    = 28;
    localparam int IDX_W      = 6;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [DIM_W-1:0]  RST_WIDTH     = 13'd1;
    localparam logic [DIM_W-1:0]  RST_HEIGHT    = 13'd1;
    localparam logic [PREC_W-1:0] RST_PRECISION = 5'd8;
    localparam logic [PREC_W-1:0] OUT_BITS      = 5'd8;

    localparam logic [IDX_W-1:0] HDR_LEN  = 6'd54;
    localparam logic [IDX_W-1:0] PIX_BLUE = 6'd54;
    localparam logic [IDX_W-1:0] PIX_GRN  = 6'd55;
    localparam logic [IDX_W-1:0] PIX_RED  = 6'd56;

    localparam logic [31:0] HDR_MAGIC_WORD = 32'h4D42_0000;
    localparam logic [31:0] HDR_OFFSET     = 32'd54;
    localparam logic [31:0] HDR_INFO_SIZE  = 32'd40;
    localparam logic [31:0] HDR_PLANES_BPP = 32'h0018_0001;

    typedef enum logic [1:0] {
        CFG_WIDTH     = 2'd0,
        CFG_HEIGHT    = 2'd1,
        CFG_PRECISION = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        HW_MAGIC   = 4'd0,
        HW_FSIZE   = 4'd1,
        HW_RSVD    = 4'd2,
        HW_OFFSET  = 4'd3,
        HW_INFO    = 4'd4,
        HW_WIDTH   = 4'd5,
        HW_HEIGHT  = 4'd6,
        HW_PLANES  = 4'd7,
        HW_COMPR   = 4'd8,
        HW_ISIZE   = 4'd9
    } hdr_word_t;

endpackage

[rtl/core/bmp24_stream_writer_top.sv]
// bmp24_stream_writer_top: pixel stream to 24-bit bmp byte stream
//
// pixels come in on the in_ channel (red, green, blue), bottom row first, left
// to right; bytes of the file leave on the out_ channel, one byte a cycle while out_stall is low.
// the first pixel of an image brings out the 54-byte header before its own
// blue, green and red bytes; the last pixel of a row adds w mod 4 zero bytes.
// run_last marks the final byte of each pixel, image_last the final file byte.
// image_width, image_height and sample_precision are written on the cfg_
// channel (index 0, 1, 2) between images or between pixels; cfg_ready is high.
// a pixel is registered at acceptance; its bytes reach the out_ port through the
// output register. a pixel gives 3 bytes on the output port, plus 54 with the
// header and 1 to 3 for row padding: the one-byte output register sets the
// rate. the next pixel is taken in the cycle its predecessor's last byte
// moves out. out_stall holds the output register and, through it, the byte
// sequencer and in_stall. reset clears the counters and the pending transaction
// and restores width 1, height 1, precision 8.
module bmp24_stream_writer_top
#(
    parameter int MAX_WIDTH  = bmp24w_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24w_pkg::DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        image_last
);

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DW    = bmp24w_pkg::DIM_W;
    localparam int IW    = bmp24w_pkg::IDX_W;

    logic [DW-1:0]                    width_reg;
    logic [DW-1:0]                    height_reg;
    logic [bmp24w_pkg::PREC_W-1:0]    prec_reg;

    logic [COL_W-1:0]                 col_reg,  col_next;
    logic [ROW_W-1:0]                 rows_reg, rows_next;
    logic                             hdr_sent_reg, hdr_sent_next;

    logic                             item_valid_reg, item_valid_next;
    logic [IW-1:0]                    idx_reg, idx_next;
    logic [7:0]                       blue_reg, green_reg, red_reg;
    logic [1:0]                       item_pad_reg;
    logic                             item_end_reg;
    logic [DW-1:0]                    item_w_reg, item_h_reg;
    logic [bmp24w_pkg::ISIZE_W-1:0]   item_isize_reg;

    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       out_byte_reg, out_byte_next;
    logic                             run_last_reg, run_last_next;
    logic                             image_last_reg, image_last_next;

    logic [DW-1:0]                    w_eff, h_eff;
    logic [bmp24w_pkg::ROWB_W-1:0]    row_bytes;
    logic [bmp24w_pkg::ISIZE_W-1:0]   isize;
    logic                             row_end, image_end;
    logic [7:0]                       blue_red, green_red, red_red;

    logic                             out_free, emit, item_done, in_acc;
    logic [IW-1:0]                    last_idx, hdr_pos;
    logic [31:0]                      hdr_word, fsize;
    logic [7:0]                       hdr_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bmp24w_pkg::RST_WIDTH;
            height_reg <= bmp24w_pkg::RST_HEIGHT;
            prec_reg   <= bmp24w_pkg::RST_PRECISION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bmp24w_pkg::CFG_WIDTH:     width_reg  <= cfg_data;
                bmp24w_pkg::CFG_HEIGHT:    height_reg <= cfg_data;
                bmp24w_pkg::CFG_PRECISION: prec_reg   <= cfg_data[bmp24w_pkg::PREC_W-1:0];
                default:                   ;
            endcase
        end
    end

    // effective dimensions
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = DW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            h_eff = DW'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        row_bytes = bmp24w_pkg::ROWB_W'(w_eff) * bmp24w_pkg::ROWB_W'(3)
                  + bmp24w_pkg::ROWB_W'(w_eff[1:0]);
        isize     = bmp24w_pkg::ISIZE_W'(row_bytes) * bmp24w_pkg::ISIZE_W'(h_eff);
        row_end   = (32'(col_reg) + 32'd1) >= 32'(w_eff);
        image_end = row_end && ((32'(rows_reg) + 32'd1) >= 32'(h_eff));
    end

    bmp24w_reduce u_reduce_blue
    (
        .sample    (blue),
        .precision (prec_reg),
        .value     (blue_red)
    );

    bmp24w_reduce u_reduce_green
    (
        .sample    (green),
        .precision (prec_reg),
        .value     (green_red)
    );

    bmp24w_reduce u_reduce_red
    (
        .sample    (red),
        .precision (prec_reg),
        .value     (red_red)
    );

    // byte sequencer handshake
    always_comb
    begin
        last_idx  = bmp24w_pkg::PIX_RED + IW'(item_pad_reg);
        out_free  = !out_valid_reg || !out_stall;
        emit      = item_valid_reg && out_free;
        item_done = emit && (idx_reg == last_idx);
        in_stall  = item_valid_reg && !item_done;
        in_acc    = in_valid && !in_stall;
    end

    // row and image counters
    always_comb
    begin
        col_next      = col_reg;
        rows_next     = rows_reg;
        hdr_sent_next = hdr_sent_reg;
        if (in_acc)
        begin
            hdr_sent_next = !image_end;
            if (row_end)
            begin
                col_next = '0;
                if (image_end)
                    rows_next = '0;
                else
                    rows_next = rows_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            rows_reg     <= '0;
            hdr_sent_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            rows_reg     <= rows_next;
            hdr_sent_reg <= hdr_sent_next;
        end
    end

    // pixel transaction register
    always_comb
    begin
        item_valid_next = item_valid_reg;
        idx_next        = idx_reg;
        if (in_acc)
        begin
            item_valid_next = 1'b1;
            idx_next        = hdr_sent_reg ? bmp24w_pkg::HDR_LEN : '0;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            blue_reg       <= blue_red;
            green_reg      <= green_red;
            red_reg        <= red_red;
            item_pad_reg   <= row_end ? w_eff[1:0] : 2'd0;
            item_end_reg   <= image_end;
            item_w_reg     <= w_eff;
            item_h_reg     <= h_eff;
            item_isize_reg <= isize;
        end
    end

    // header byte select: every header word starts two bytes off a 4-byte boundary
    always_comb
    begin
        hdr_pos = idx_reg + IW'(2);
        fsize   = 32'(item_isize_reg) + bmp24w_pkg::HDR_OFFSET;
        case (hdr_pos[IW-1:2])
            bmp24w_pkg::HW_MAGIC:  hdr_word = bmp24w_pkg::HDR_MAGIC_WORD;
            bmp24w_pkg::HW_FSIZE:  hdr_word = fsize;
            bmp24w_pkg::HW_OFFSET: hdr_word = bmp24w_pkg::HDR_OFFSET;
            bmp24w_pkg::HW_INFO:   hdr_word = bmp24w_pkg::HDR_INFO_SIZE;
            bmp24w_pkg::HW_WIDTH:  hdr_word = 32'(item_w_reg);
            bmp24w_pkg::HW_HEIGHT: hdr_word = 32'(item_h_reg);
            bmp24w_pkg::HW_PLANES: hdr_word = bmp24w_pkg::HDR_PLANES_BPP;
            bmp24w_pkg::HW_ISIZE:  hdr_word = 32'(item_isize_reg);
            default:               hdr_word = 32'd0;
        endcase
        hdr_byte = 8'(hdr_word >> {hdr_pos[1:0], 3'b000});
    end

    // output register
    always_comb
    begin
        out_valid_next  = emit || (out_valid_reg && out_stall);
        out_byte_next   = out_byte_reg;
        run_last_next   = run_last_reg;
        image_last_next = image_last_reg;
        if (emit)
        begin
            if (idx_reg < bmp24w_pkg::HDR_LEN)
                out_byte_next = hdr_byte;
            else if (idx_reg == bmp24w_pkg::PIX_BLUE)
                out_byte_next = blue_reg;
            else if (idx_reg == bmp24w_pkg::PIX_GRN)
                out_byte_next = green_reg;
            else if (idx_reg == bmp24w_pkg::PIX_RED)
                out_byte_next = red_reg;
            else
                out_byte_next = 8'd0;
            run_last_next   = (idx_reg == last_idx);
            image_last_next = (idx_reg == last_idx) && item_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        run_last_reg   <= run_last_next;
        image_last_reg <= image_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign run_last   = run_last_reg;
    assign image_last = image_last_reg;

endmodule

[rtl/core/bmp24w_reduce.sv]
// bmp24w_reduce: rounds one colour sample down to eight bits and saturates it
module bmp24w_reduce
(
    input  logic [bmp24w_pkg::SAMPLE_W-1:0] sample,
    input  logic [bmp24w_pkg::PREC_W-1:0]   precision,
    output logic [7:0]                      value
);

    logic [bmp24w_pkg::PREC_W-1:0]   shift;
    logic [bmp24w_pkg::SAMPLE_W-1:0] shifted;
    logic [bmp24w_pkg::SAMPLE_W-1:0] half;
    logic [bmp24w_pkg::SAMPLE_W:0]   rounded;

    always_comb
    begin
        shift   = precision - bmp24w_pkg::OUT_BITS;
        shifted = sample >> shift;
        half    = sample >> (shift - 5'd1);
        if (precision > bmp24w_pkg::OUT_BITS)
        begin
            rounded = {1'b0, shifted} + {{bmp24w_pkg::SAMPLE_W{1'b0}}, half[0]};
        end
        else
        begin
            rounded = {1'b0, sample};
        end
        if (rounded > 17'd255)
        begin
            value = 8'hFF;
        end
        else
        begin
            value = rounded[7:0];
        end
    end

endmodule
